@@ rtl/kme_pkg.sv @@
`default_nettype none
package kme_pkg;

   localparam int DefaultRows = 7;
   localparam int DefaultCols = 5;

   localparam int RomCols     = 5;
   localparam int RomRows     = 7;
   localparam int HoldKeys    = 3;
   localparam int MaxResults  = 34;
   localparam int ProbeBits   = 64;

   localparam int HoldTimeWidth = 16;
   localparam int CodeWidth     = 8;
   localparam int TimeWidth     = 32;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrHoldTime  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBackspace = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrReturn    = 2'd2;

   localparam logic [HoldTimeWidth-1:0] HoldTimeReset  = 16'd280;
   localparam logic [CodeWidth-1:0]     BackspaceReset = 8'd178;
   localparam logic [CodeWidth-1:0]     ReturnReset    = 8'd176;

   localparam int SymbolCol    = 0;
   localparam int SymbolRow    = 2;
   localparam int ShiftACol    = 1;
   localparam int ShiftARow    = 6;
   localparam int ShiftBCol    = 2;
   localparam int ShiftBRow    = 3;
   localparam int EnterCol     = 3;
   localparam int EnterRow     = 3;
   localparam int BackspaceCol = 4;
   localparam int BackspaceRow = 3;

   localparam logic [CodeWidth-1:0] LetterRom [RomCols][RomRows] = '{
      '{8'h71, 8'h77, 8'h00, 8'h61, 8'h00, 8'h20, 8'h00},
      '{8'h65, 8'h73, 8'h64, 8'h70, 8'h78, 8'h7a, 8'h00},
      '{8'h72, 8'h67, 8'h74, 8'h00, 8'h76, 8'h63, 8'h66},
      '{8'h75, 8'h68, 8'h79, 8'h00, 8'h62, 8'h6e, 8'h6a},
      '{8'h6f, 8'h6c, 8'h69, 8'h00, 8'h24, 8'h6d, 8'h6b}
   };

   localparam logic [CodeWidth-1:0] SymbolRom [RomCols][RomRows] = '{
      '{8'h23, 8'h31, 8'h00, 8'h2a, 8'h00, 8'h00, 8'h30},
      '{8'h32, 8'h34, 8'h35, 8'h40, 8'h38, 8'h37, 8'h00},
      '{8'h33, 8'h2f, 8'h28, 8'h00, 8'h3f, 8'h39, 8'h36},
      '{8'h5f, 8'h3a, 8'h29, 8'h00, 8'h21, 8'h2c, 8'h3b},
      '{8'h2b, 8'h22, 8'h2d, 8'h00, 8'h00, 8'h2e, 8'h27}
   };

   localparam int HoldCol [HoldKeys] = '{1, 3, 4};
   localparam int HoldRow [HoldKeys] = '{2, 1, 1};
   localparam logic [CodeWidth-1:0] HoldShort [HoldKeys] = '{8'h64, 8'h68, 8'h6c};
   localparam logic [CodeWidth-1:0] HoldLong  [HoldKeys] = '{8'h66, 8'h6a, 8'h6b};

   typedef struct packed {
      logic [HoldTimeWidth-1:0] hold_time;
      logic [CodeWidth-1:0]     backspace_code;
      logic [CodeWidth-1:0]     return_code;
   } kme_cfg_type;

   typedef struct packed {
      logic                 push;
      logic [CodeWidth-1:0] code;
      logic                 done;
   } kme_emit_type;

   function automatic logic bit_at(logic [ProbeBits-1:0] v, int c, int r, int rows);
      int idx;
      idx = c * rows + r;
      if (idx >= ProbeBits) return 1'b0;
      return v[idx[5:0]];
   endfunction

   function automatic logic [CodeWidth-1:0] letter_get(int c, int r);
      if (c >= RomCols || r >= RomRows) return '0;
      return LetterRom[c][r];
   endfunction

   function automatic logic [CodeWidth-1:0] symbol_get(int c, int r);
      if (c >= RomCols || r >= RomRows) return '0;
      return SymbolRom[c][r];
   endfunction

   function automatic logic is_hold_key(int c, int r);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < HoldKeys; i++) begin
         if (HoldCol[i] == c && HoldRow[i] == r) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [CodeWidth-1:0] shift_code(logic shift_on,
                                                       logic [CodeWidth-1:0] ch);
      if (shift_on && ch >= 8'h61 && ch <= 8'h7a) return ch - 8'd32;
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ rtl/keyboard_matrix_key_encoder.sv @@
// Keyboard matrix key encoder.
// req channel: one matrix scan per item (req_key_states, bit col*rows+row,
// 1 = pressed) with its millisecond timestamp req_now_ms. req_stall is high
// while a scan is being worked on.
// rsp channel: zero or more key codes per scan; rsp_last_of_scan marks the
// final code of a scan. A scan that causes no code gives no item.
// A scan steps from acceptance to the next acceptance through each dual-role
// key via the shared elapsed-time subtract and compare, then each matrix
// position through the layout lookup, then enter and a closing step. Each code
// waits in a pending register until the next code or the closing step decides
// rsp_last_of_scan, and reaches rsp in the cycle after that step.
// csr port: write hold time, backspace and enter codes while idle.
// Reset (synchronous) restores the register defaults and clears the key, latch
// and hold tracking flags; hold start times and scan samples are not reset.
// A stall on rsp holds the output register; one more code waits in a pending
// register, after which the sequencer holds until the receiver takes one.
`default_nettype none
module keyboard_matrix_key_encoder
   import kme_pkg::*;
#(
   parameter int MATRIX_ROWS = DefaultRows,
   parameter int MATRIX_COLS = DefaultCols
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [MATRIX_ROWS*MATRIX_COLS-1:0] req_key_states,
   input  wire logic [TimeWidth-1:0]               req_now_ms,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [CodeWidth-1:0]                    rsp_key_code,
   output logic                                    rsp_last_of_scan,
   input  wire logic                               csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0]           csr_index,
   input  wire logic [CsrDataWidth-1:0]            csr_wr_data
);

   kme_cfg_type  cfg_ff, cfg_in;
   kme_emit_type emit;
   logic         emit_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CsrHoldTime:  cfg_in.hold_time      = csr_wr_data;
            CsrBackspace: cfg_in.backspace_code = csr_wr_data[CodeWidth-1:0];
            CsrReturn:    cfg_in.return_code    = csr_wr_data[CodeWidth-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time      <= HoldTimeReset;
         cfg_ff.backspace_code <= BackspaceReset;
         cfg_ff.return_code    <= ReturnReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kme_seq #(
      .MATRIX_ROWS(MATRIX_ROWS),
      .MATRIX_COLS(MATRIX_COLS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_key_states(req_key_states),
      .req_now_ms    (req_now_ms),
      .cfg           (cfg_ff),
      .emit_ok       (emit_ok),
      .emit          (emit)
   );

   kme_out u_out (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .emit_ok         (emit_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_code    (rsp_key_code),
      .rsp_last_of_scan(rsp_last_of_scan)
   );

endmodule
`default_nettype wire

@@ rtl/kme_out.sv @@
`default_nettype none
module kme_out
   import kme_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kme_emit_type         emit,
   output logic                      emit_ok,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CodeWidth-1:0]      rsp_key_code,
   output logic                      rsp_last_of_scan
);

   logic                 pend_valid_ff, pend_valid_in;
   logic [CodeWidth-1:0] pend_code_ff, pend_code_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CodeWidth-1:0] out_code_ff, out_code_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_free;
   logic                 move;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit_ok  = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_code_in   = out_code_ff;
      out_last_in   = out_last_ff;
      move          = pend_valid_ff && out_free && (emit.push || emit.done);
      if (move) begin
         out_valid_in = 1'b1;
         out_code_in  = pend_code_ff;
         out_last_in  = emit.done;
      end
      if (emit.push && emit_ok) begin
         pend_valid_in = 1'b1;
         pend_code_in  = emit.code;
      end else if (emit.done && emit_ok) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_code_ff <= pend_code_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_key_code     = out_code_ff;
   assign rsp_last_of_scan = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/kme_seq.sv @@
`default_nettype none
module kme_seq
   import kme_pkg::*;
#(
   parameter int MATRIX_ROWS = DefaultRows,
   parameter int MATRIX_COLS = DefaultCols
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [MATRIX_ROWS*MATRIX_COLS-1:0] req_key_states,
   input  wire logic [TimeWidth-1:0]               req_now_ms,
   input  wire kme_cfg_type                        cfg,
   input  wire logic                               emit_ok,
   output kme_emit_type                            emit
);

   localparam int KeyBits = MATRIX_ROWS * MATRIX_COLS;
   localparam int RowW    = $clog2(MATRIX_ROWS);
   localparam int ColW    = $clog2(MATRIX_COLS);
   localparam int CountW  = $clog2(MaxResults + 1);
   localparam int HoldW   = $clog2(HoldKeys);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StHold  = 3'd1;
   localparam logic [2:0] StScan  = 3'd2;
   localparam logic [2:0] StEnter = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [ProbeBits-1:0] keys_ff, keys_in;
   logic [ProbeBits-1:0] fresh_ff, fresh_in;
   logic [ProbeBits-1:0] prev_ff, prev_in;
   logic                 armed_ff, armed_in;
   logic [TimeWidth-1:0] now_ff, now_in;
   logic [HoldKeys-1:0]  trk_ff, trk_in;
   logic [HoldKeys-1:0]  long_ff, long_in;
   logic [TimeWidth-1:0] start_ff [HoldKeys];
   logic [TimeWidth-1:0] start_in [HoldKeys];
   logic [HoldW-1:0]     hidx_ff, hidx_in;
   logic [RowW-1:0]      row_ff, row_in;
   logic [ColW-1:0]      col_ff, col_in;
   logic [CountW-1:0]    count_ff, count_in;

   logic [ProbeBits-1:0] keys64;
   logic [ProbeBits-1:0] fresh64;
   logic                 shift_on;
   logic                 want;
   logic [CodeWidth-1:0] code;
   logic                 do_push;
   logic                 step_go;
   logic                 pressed;
   logic [TimeWidth-1:0] elapsed;
   logic                 reached;
   logic                 key_fresh;
   logic                 at_bs;
   logic                 on_hold;
   logic [CodeWidth-1:0] letter;
   logic [CodeWidth-1:0] sym;
   logic [CodeWidth-1:0] pick;
   logic                 printable;
   int                   hc, hr;

   generate
      if (KeyBits >= ProbeBits) begin : g_trunc
         assign keys64 = req_key_states[ProbeBits-1:0];
      end else begin : g_ext
         assign keys64 = {{(ProbeBits-KeyBits){1'b0}}, req_key_states};
      end
   endgenerate

   assign fresh64   = keys64 & ~prev_ff;
   assign req_stall = (state_ff != StIdle);

   always_comb begin
      hc       = HoldCol[hidx_ff];
      hr       = HoldRow[hidx_ff];
      shift_on = bit_at(keys_ff, ShiftACol, ShiftARow, MATRIX_ROWS) ||
                 bit_at(keys_ff, ShiftBCol, ShiftBRow, MATRIX_ROWS);
      pressed  = bit_at(keys_ff, hc, hr, MATRIX_ROWS);
      elapsed  = now_ff - start_ff[hidx_ff];
      reached  = elapsed >= {{(TimeWidth-HoldTimeWidth){1'b0}}, cfg.hold_time};

      key_fresh = bit_at(fresh_ff, int'(col_ff), int'(row_ff), MATRIX_ROWS);
      at_bs     = (int'(col_ff) == BackspaceCol) && (int'(row_ff) == BackspaceRow);
      on_hold   = is_hold_key(int'(col_ff), int'(row_ff));
      letter    = letter_get(int'(col_ff), int'(row_ff));
      sym       = symbol_get(int'(col_ff), int'(row_ff));
      pick      = (armed_ff && sym != '0) ? sym : letter;
      printable = key_fresh && !at_bs && (letter != '0 || sym != '0) &&
                  (armed_ff || !on_hold);

      want = 1'b0;
      code = '0;
      case (state_ff)
         StHold: begin
            if (pressed) begin
               want = trk_ff[hidx_ff] && !long_ff[hidx_ff] && reached;
               code = shift_code(shift_on, HoldLong[hidx_ff]);
            end else begin
               want = trk_ff[hidx_ff] && !long_ff[hidx_ff];
               code = shift_code(shift_on, HoldShort[hidx_ff]);
            end
         end
         StScan: begin
            if (key_fresh && at_bs) begin
               want = 1'b1;
               code = cfg.backspace_code;
            end else begin
               want = printable && pick != '0;
               code = shift_code(shift_on, pick);
            end
         end
         StEnter: begin
            want = bit_at(fresh_ff, EnterCol, EnterRow, MATRIX_ROWS);
            code = cfg.return_code;
         end
         default: begin
            want = 1'b0;
            code = '0;
         end
      endcase

      do_push = want && (count_ff < CountW'(MaxResults));
      step_go = !do_push || emit_ok;

      emit.push = do_push && emit_ok;
      emit.code = code;
      emit.done = (state_ff == StDone) && emit_ok;
   end

   always_comb begin
      state_in = state_ff;
      keys_in  = keys_ff;
      fresh_in = fresh_ff;
      prev_in  = prev_ff;
      armed_in = armed_ff;
      now_in   = now_ff;
      trk_in   = trk_ff;
      long_in  = long_ff;
      start_in = start_ff;
      hidx_in  = hidx_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      count_in = count_ff;
      if (emit.push) count_in = count_ff + CountW'(1);
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               keys_in  = keys64;
               fresh_in = fresh64;
               prev_in  = keys64;
               now_in   = req_now_ms;
               if (bit_at(fresh64, SymbolCol, SymbolRow, MATRIX_ROWS)) armed_in = 1'b1;
               hidx_in  = '0;
               row_in   = '0;
               col_in   = '0;
               count_in = '0;
               state_in = StHold;
            end
         end
         StHold: begin
            if (step_go) begin
               if (pressed) begin
                  if (!trk_ff[hidx_ff]) begin
                     trk_in[hidx_ff]   = 1'b1;
                     long_in[hidx_ff]  = 1'b0;
                     start_in[hidx_ff] = now_ff;
                  end else if (!long_ff[hidx_ff] && reached) begin
                     long_in[hidx_ff] = 1'b1;
                  end
               end else begin
                  trk_in[hidx_ff]  = 1'b0;
                  long_in[hidx_ff] = 1'b0;
               end
               if (hidx_ff == HoldW'(HoldKeys - 1)) begin
                  state_in = StScan;
               end else begin
                  hidx_in = hidx_ff + HoldW'(1);
               end
            end
         end
         StScan: begin
            if (step_go) begin
               if (printable && armed_ff) armed_in = 1'b0;
               if (col_ff == ColW'(MATRIX_COLS - 1)) begin
                  col_in = '0;
                  if (row_ff == RowW'(MATRIX_ROWS - 1)) begin
                     state_in = StEnter;
                  end else begin
                     row_in = row_ff + RowW'(1);
                  end
               end else begin
                  col_in = col_ff + ColW'(1);
               end
            end
         end
         StEnter: begin
            if (step_go) state_in = StDone;
         end
         StDone: begin
            if (emit_ok) state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         prev_ff  <= '0;
         armed_ff <= 1'b0;
         trk_ff   <= '0;
         long_ff  <= '0;
         hidx_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         armed_ff <= armed_in;
         trk_ff   <= trk_in;
         long_ff  <= long_in;
         hidx_ff  <= hidx_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         count_ff <= count_in;
      end
      keys_ff  <= keys_in;
      fresh_ff <= fresh_in;
      now_ff   <= now_in;
      start_ff <= start_in;
   end

endmodule
`default_nettype wire
